@@ hw/rtl/dcfe_pkg.sv @@
// ----------------------------------------------------------------------------
// dcfe_pkg
// Shared constants, codes and controller/datapath interface types of the
// DMX channel fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfe_pkg;

  localparam int NUM_CHANNELS = 512;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(NUM_CHANNELS - 1);

  localparam int CH_W      = 10;
  localparam int LEVEL_W   = 8;
  localparam int FADE_W    = 24;
  localparam int TIME_W    = 32;
  localparam int TP_W      = 10;
  localparam int ELAPSED_W = TIME_W + TP_W;
  localparam int PROD_W    = LEVEL_W + FADE_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int PAR_W     = 2 * LEVEL_W + FADE_W + TIME_W;
  localparam int DIV_STEPS = LEVEL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CH_W:0]   MAX_CH    = (CH_W + 1)'(NUM_CHANNELS);
  localparam logic [TP_W-1:0] TP_RESET  = TP_W'(10);

  localparam logic [1:0] FUNC_SET  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_STOP = 2'd3;

  typedef struct packed {
    logic capture;
    logic idx_inc;
    logic wr_clear;
    logic wr_stop;
    logic set_exec;
    logic read_exec;
    logic res_invalid;
    logic res_done;
    logic mul_e;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_step;
    logic t_wr;
  } dcfe_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       ch_valid;
    logic       idx_last;
    logic       act;
    logic       ended;
    logic       div_last;
  } dcfe_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/dcfe_ram.sv @@
// ----------------------------------------------------------------------------
// dcfe_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/dcfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcfe_ctrl
// Sequencer of the fade engine: reset clearing pass, command decode, channel
// walk for ticks and stop-all, and the per-channel fade arithmetic steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfe_ctrl import dcfe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire dcfe_sts_t sts_i,
  output dcfe_cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_LOOK  = 4'd2;
  localparam logic [3:0] ST_SET   = 4'd3;
  localparam logic [3:0] ST_READ  = 4'd4;
  localparam logic [3:0] ST_STOP  = 4'd5;
  localparam logic [3:0] ST_CHK   = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_MULB  = 4'd8;
  localparam logic [3:0] ST_SUM   = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_WR    = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_LOOK: begin
        unique case (sts_i.func) inside
          FUNC_SET, FUNC_READ: begin
            if (!sts_i.ch_valid) begin
              cmd_o.res_invalid = 1'b1;
              state_d           = ST_IDLE;
            end else if (sts_i.func == FUNC_SET) begin
              state_d = ST_SET;
            end else begin
              state_d = ST_READ;
            end
          end
          FUNC_TICK: state_d = ST_CHK;
          default:   state_d = ST_STOP;
        endcase
      end
      ST_SET: begin
        cmd_o.set_exec = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_READ: begin
        cmd_o.read_exec = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_STOP: begin
        cmd_o.wr_stop = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.res_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_CHK: begin
        if (sts_i.act) begin
          cmd_o.mul_e = 1'b1;
          state_d     = ST_CMP;
        end else if (sts_i.idx_last) begin
          cmd_o.res_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_CMP: begin
        if (sts_i.ended) begin
          state_d = ST_WR;
        end else begin
          cmd_o.mul_a = 1'b1;
          state_d     = ST_MULB;
        end
      end
      ST_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        cmd_o.t_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.res_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/dcfe_datapath.sv @@
// ----------------------------------------------------------------------------
// dcfe_datapath
// Level, fade flag and fade parameter stores, the item and result registers,
// and the elapsed-time multiply, blend products and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfe_datapath import dcfe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dcfe_cmd_t            cmd_i,
  output dcfe_sts_t                 sts_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [CH_W-1:0]      channel_i,
  input  wire logic [LEVEL_W-1:0]   level_i,
  input  wire logic [FADE_W-1:0]    fade_ms_i,
  input  wire logic [TIME_W-1:0]    now_ticks_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [TP_W-1:0]      cfg_data_i,
  output logic                      done_o,
  output logic                      status_o,
  output logic [LEVEL_W-1:0]        read_level_o,
  output logic                      fading_o,
  output logic                      frame_changed_o
);

  logic [1:0]           func_q;
  logic [LEVEL_W-1:0]   lvl_in_q;
  logic [FADE_W-1:0]    fms_q;
  logic [TIME_W-1:0]    now_q;
  logic                 ch_valid_q;
  logic [CH_IDX_W-1:0]  addr_q;
  logic [TP_W-1:0]      tp_q;
  logic [ELAPSED_W-1:0] e_q;
  logic [PROD_W-1:0]    a_q, b_q;
  logic [NUM_W-1:0]     rem_q, dsh_q;
  logic [LEVEL_W-1:0]   quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 any_q;
  logic                 done_q, status_q, fading_q, changed_q;
  logic [LEVEL_W-1:0]   rd_lvl_q;

  logic                 ch_valid_in;
  logic [CH_IDX_W-1:0]  addr_in;
  logic [LEVEL_W-1:0]   lvl_rd, lvl_wd, next_lvl;
  logic [0:0]           act_rd, act_wd;
  logic [PAR_W-1:0]     par_rd, par_wd;
  logic                 lvl_we, act_we, par_we;
  logic [LEVEL_W-1:0]   p_start, p_target;
  logic [FADE_W-1:0]    p_dur;
  logic [TIME_W-1:0]    p_time, diff;
  logic                 ended, ge;

  assign ch_valid_in = (channel_i != '0) && ({1'b0, channel_i} <= MAX_CH);
  assign addr_in = (ch_valid_in && (func_i == FUNC_SET || func_i == FUNC_READ)) ?
                   CH_IDX_W'(channel_i - CH_W'(1)) : '0;

  dcfe_ram #(.WIDTH(LEVEL_W), .DEPTH(NUM_CHANNELS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (addr_q),
    .wdata_i (lvl_wd),
    .raddr_i (addr_q),
    .rdata_o (lvl_rd)
  );

  dcfe_ram #(.WIDTH(1), .DEPTH(NUM_CHANNELS)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (addr_q),
    .wdata_i (act_wd),
    .raddr_i (addr_q),
    .rdata_o (act_rd)
  );

  dcfe_ram #(.WIDTH(PAR_W), .DEPTH(NUM_CHANNELS)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (addr_q),
    .wdata_i (par_wd),
    .raddr_i (addr_q),
    .rdata_o (par_rd)
  );

  assign {p_start, p_target, p_dur, p_time} = par_rd;
  assign par_wd   = {lvl_rd, lvl_in_q, fms_q, now_q};
  assign diff     = now_q - p_time;
  assign ended    = (e_q >= ELAPSED_W'(p_dur));
  assign ge       = (rem_q >= dsh_q);
  assign next_lvl = ended ? p_target : quo_q;

  always_comb begin
    lvl_we = 1'b0;
    lvl_wd = lvl_in_q;
    act_we = 1'b0;
    act_wd = 1'b0;
    par_we = 1'b0;
    if (cmd_i.wr_clear) begin
      lvl_we = 1'b1;
      lvl_wd = '0;
      act_we = 1'b1;
    end
    if (cmd_i.wr_stop) begin
      act_we = 1'b1;
    end
    if (cmd_i.set_exec) begin
      act_we = 1'b1;
      if (fms_q != '0) begin
        par_we = 1'b1;
        act_wd = 1'b1;
      end else begin
        lvl_we = 1'b1;
      end
    end
    if (cmd_i.t_wr) begin
      lvl_wd = next_lvl;
      lvl_we = (next_lvl != lvl_rd);
      act_we = ended;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      tp_q   <= TP_RESET;
      done_q <= 1'b0;
      any_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tp_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        addr_q <= addr_in;
        any_q  <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        addr_q <= addr_q + CH_IDX_W'(1);
      end
      if (cmd_i.t_wr && lvl_we) begin
        any_q <= 1'b1;
      end
      done_q <= cmd_i.res_invalid | cmd_i.res_done | cmd_i.set_exec | cmd_i.read_exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= func_i;
      lvl_in_q   <= level_i;
      fms_q      <= fade_ms_i;
      now_q      <= now_ticks_i;
      ch_valid_q <= ch_valid_in;
    end
    if (cmd_i.mul_e) begin
      e_q <= ELAPSED_W'(diff) * ELAPSED_W'(tp_q);
    end
    // Past this point the fade has not ended, so the elapsed time is below
    // the 24-bit duration and its low bits carry the whole value.
    if (cmd_i.mul_a) begin
      a_q <= PROD_W'(p_start) * PROD_W'(p_dur - e_q[FADE_W-1:0]);
    end
    if (cmd_i.mul_b) begin
      b_q <= PROD_W'(p_target) * PROD_W'(e_q[FADE_W-1:0]);
    end
    // The quotient never exceeds 255, so eight restoring steps starting at
    // the divisor shifted up by seven cover it.
    if (cmd_i.sum) begin
      rem_q <= NUM_W'({a_q, 1'b0}) + NUM_W'({b_q, 1'b0}) + NUM_W'(p_dur);
      dsh_q <= NUM_W'({p_dur, 1'b0}) << (DIV_STEPS - 1);
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[LEVEL_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.res_invalid) begin
      status_q  <= 1'b1;
      rd_lvl_q  <= '0;
      fading_q  <= 1'b0;
      changed_q <= 1'b0;
    end else if (cmd_i.res_done) begin
      status_q  <= 1'b0;
      rd_lvl_q  <= '0;
      fading_q  <= 1'b0;
      changed_q <= any_q | (cmd_i.t_wr & lvl_we);
    end else if (cmd_i.set_exec) begin
      status_q  <= 1'b0;
      rd_lvl_q  <= '0;
      fading_q  <= 1'b0;
      changed_q <= (fms_q == '0) && (lvl_rd != lvl_in_q);
    end else if (cmd_i.read_exec) begin
      status_q  <= 1'b0;
      rd_lvl_q  <= lvl_rd;
      fading_q  <= act_rd[0];
      changed_q <= 1'b0;
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.ch_valid = ch_valid_q;
  assign sts_o.idx_last = (addr_q == LAST_IDX);
  assign sts_o.act      = act_rd[0];
  assign sts_o.ended    = ended;
  assign sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_level_o    = rd_lvl_q;
  assign fading_o        = fading_q;
  assign frame_changed_o = changed_q;

endmodule

`default_nettype wire

@@ hw/rtl/dmx_channel_fade_engine_core.sv @@
// ----------------------------------------------------------------------------
// dmx_channel_fade_engine_core
// 512-channel DMX level table with per-channel linear fades.
//
//   channel   signals                                          handshake
//   command   func_i channel_i level_i fade_ms_i now_ticks_i   start_i & !busy_o
//   result    status_o read_level_o fading_o frame_changed_o   done_o, one cycle
//   config    cfg_data_i (tick period in ms)                   cfg_we_i
//
// Stop-all writes one flag per channel. A tick visits every channel: an idle
// channel is skipped, a fade that ends writes its target level, and one in
// progress runs the multiplies and the 8-step divider.
// After reset a clearing pass over all channels runs with busy_o high.
// The receiver cannot stall; each result is shown once, for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_channel_fade_engine_core import dcfe_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [CH_W-1:0]    channel_i,
  input  wire logic [LEVEL_W-1:0] level_i,
  input  wire logic [FADE_W-1:0]  fade_ms_i,
  input  wire logic [TIME_W-1:0]  now_ticks_i,
  input  wire logic               cfg_we_i,
  input  wire logic [TP_W-1:0]    cfg_data_i,
  output logic                    done_o,
  output logic                    status_o,
  output logic [LEVEL_W-1:0]      read_level_o,
  output logic                    fading_o,
  output logic                    frame_changed_o
);

  dcfe_cmd_t cmd;
  dcfe_sts_t sts;

  dcfe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  dcfe_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .channel_i       (channel_i),
    .level_i         (level_i),
    .fade_ms_i       (fade_ms_i),
    .now_ticks_i     (now_ticks_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_level_o    (read_level_o),
    .fading_o        (fading_o),
    .frame_changed_o (frame_changed_o)
  );

`ifndef SYNTHESIS
  // Every result is issued as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted command did not start work");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (!frame_changed_o && !fading_o && read_level_o == '0))
    else $error("invalid channel result carries data");
`endif

endmodule

`default_nettype wire
